/* rtl/core/lscf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_pkg
// Shared types and constants of the circle fit unit: beat layouts of the point
// and result channels, status codes and output limits.
// ----------------------------------------------------------------------------
package lscf_pkg;

   localparam int COORD_W = 16;
   localparam int CEN_W = 20;
   localparam int RAD_W = 19;
   localparam int STAT_W = 2;
   localparam int MIN_POINTS = 3;

   localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FEW = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SINGULAR = 2'd2;
   localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd3;

   localparam logic signed [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
   localparam logic signed [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};
   localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               end_of_set;
   } req_type;

   typedef struct packed {
      logic signed [CEN_W-1:0] center_x;
      logic signed [CEN_W-1:0] center_y;
      logic [RAD_W-1:0]        radius;
      logic [STAT_W-1:0]       fit_status;
   } rsp_type;

endpackage

/* rtl/core/lscf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_front
// Point pipeline: squares, cubes and cross products over three stages, then
// the count and moment sums; a point set closes into a snapshot on its last
// beat and the sums clear.
// ----------------------------------------------------------------------------
module lscf_front
   import lscf_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   localparam int CW = $clog2(MAX_POINTS + 1),
   localparam int S1W = COORD_W + CW,
   localparam int S2W = 2 * COORD_W + CW,
   localparam int S3W = 3 * COORD_W + CW,
   localparam int SNAP_W = 1 + CW + 2 * S1W + 3 * S2W + 4 * S3W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  req_type           req_point,
   output logic              snap_valid,
   input  logic              snap_ready,
   output logic [SNAP_W-1:0] snap_data
);

   typedef struct packed {
      logic           ovf;
      logic [CW-1:0]  n;
      logic [S1W-1:0] sx;
      logic [S1W-1:0] sy;
      logic [S2W-1:0] sxx;
      logic [S2W-1:0] syy;
      logic [S2W-1:0] sxy;
      logic [S3W-1:0] sxxx;
      logic [S3W-1:0] syyy;
      logic [S3W-1:0] sxyy;
      logic [S3W-1:0] sxxy;
   } snap_type;

   localparam logic [CW-1:0] MAX_N = CW'(MAX_POINTS);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff, s2_x_ff, s2_y_ff, s3_x_ff, s3_y_ff;
   logic [2*COORD_W-1:0] s2_xx_ff, s2_yy_ff, s2_xy_ff, s3_xx_ff, s3_yy_ff, s3_xy_ff;
   logic [3*COORD_W-1:0] s3_xxx_ff, s3_yyy_ff, s3_xyy_ff, s3_xxy_ff;

   snap_type sums_ff, sums_in, next_sums;
   logic stall, advance, take;

   assign stall = s3_valid_ff && s3_last_ff && !snap_ready;
   assign advance = !stall;
   assign req_full = stall;
   assign snap_valid = s3_valid_ff && s3_last_ff;
   assign snap_data = next_sums;

   always_comb begin
      take = sums_ff.n < MAX_N;
      next_sums = sums_ff;
      if (take) begin
         next_sums.n = sums_ff.n + CW'(1);
         next_sums.sx = sums_ff.sx + S1W'(s3_x_ff);
         next_sums.sy = sums_ff.sy + S1W'(s3_y_ff);
         next_sums.sxx = sums_ff.sxx + S2W'(s3_xx_ff);
         next_sums.syy = sums_ff.syy + S2W'(s3_yy_ff);
         next_sums.sxy = sums_ff.sxy + S2W'(s3_xy_ff);
         next_sums.sxxx = sums_ff.sxxx + S3W'(s3_xxx_ff);
         next_sums.syyy = sums_ff.syyy + S3W'(s3_yyy_ff);
         next_sums.sxyy = sums_ff.sxyy + S3W'(s3_xyy_ff);
         next_sums.sxxy = sums_ff.sxxy + S3W'(s3_xxy_ff);
      end else begin
         next_sums.ovf = 1'b1;
      end
      sums_in = sums_ff;
      if (s3_valid_ff && advance) begin
         sums_in = s3_last_ff ? '0 : next_sums;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
         if (advance) begin
            s1_valid_ff <= req_push;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff <= req_point.point_x;
         s1_y_ff <= req_point.point_y;
         s1_last_ff <= req_point.end_of_set;
         s2_x_ff <= s1_x_ff;
         s2_y_ff <= s1_y_ff;
         s2_last_ff <= s1_last_ff;
         s2_xx_ff <= 32'(s1_x_ff) * 32'(s1_x_ff);
         s2_yy_ff <= 32'(s1_y_ff) * 32'(s1_y_ff);
         s2_xy_ff <= 32'(s1_x_ff) * 32'(s1_y_ff);
         s3_x_ff <= s2_x_ff;
         s3_y_ff <= s2_y_ff;
         s3_last_ff <= s2_last_ff;
         s3_xx_ff <= s2_xx_ff;
         s3_yy_ff <= s2_yy_ff;
         s3_xy_ff <= s2_xy_ff;
         s3_xxx_ff <= 48'(s2_xx_ff) * 48'(s2_x_ff);
         s3_yyy_ff <= 48'(s2_yy_ff) * 48'(s2_y_ff);
         s3_xyy_ff <= 48'(s2_yy_ff) * 48'(s2_x_ff);
         s3_xxy_ff <= 48'(s2_xx_ff) * 48'(s2_y_ff);
      end
   end

endmodule

/* rtl/core/lscf_snap_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_snap_queue
// Two-entry queue of closed point sets between the accumulator and the
// solver.
// ----------------------------------------------------------------------------
module lscf_snap_queue
   import lscf_pkg::*;
#(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  logic [W-1:0] wr_data,
   output logic         rd_valid,
   input  logic         rd_ready,
   output logic [W-1:0] rd_data
);

   logic [W-1:0] mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign wr_ready = count_ff != 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/lscf_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscf_solver
// Sequenced solve of the normal equations: a microcoded shift-add multiplier
// with accumulator, a restoring centre divider, a mean divider and a
// bit-pair square root.
// ----------------------------------------------------------------------------
module lscf_solver
   import lscf_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   localparam int CW = $clog2(MAX_POINTS + 1),
   localparam int S1W = COORD_W + CW,
   localparam int S2W = 2 * COORD_W + CW,
   localparam int S3W = 3 * COORD_W + CW,
   localparam int SNAP_W = 1 + CW + 2 * S1W + 3 * S2W + 4 * S3W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   output logic              snap_ready,
   input  logic [SNAP_W-1:0] snap_data,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_type           res_data
);

   typedef struct packed {
      logic           ovf;
      logic [CW-1:0]  n;
      logic [S1W-1:0] sx;
      logic [S1W-1:0] sy;
      logic [S2W-1:0] sxx;
      logic [S2W-1:0] syy;
      logic [S2W-1:0] sxy;
      logic [S3W-1:0] sxxx;
      logic [S3W-1:0] syyy;
      logic [S3W-1:0] sxyy;
      logic [S3W-1:0] sxxy;
   } snap_type;

   typedef struct packed {
      logic [4:0] a_sel;
      logic [4:0] b_sel;
      logic [1:0] opc;
      logic [3:0] dest;
   } uop_type;

   localparam int BW = 4 * CW + 88;
   localparam int TW = 2 * ((CW + 45) / 2);
   localparam int TCW = $clog2(TW + 1);
   localparam int QW = CEN_W + 1;
   localparam int KW = $clog2(QW);

   localparam logic [QW-1:0] Q_SAT = QW'(1) << CEN_W;
   localparam logic [QW-1:0] Q_NEG_LIM = QW'(1) << (CEN_W - 1);
   localparam logic [TW-1:0] SQ_TOP = TW'(1) << (TW - 2);
   localparam logic [TCW-1:0] DIV_STEPS = TCW'(TW);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL_SETUP = 4'd1;
   localparam logic [3:0] S_MUL = 4'd2;
   localparam logic [3:0] S_MUL_ACC = 4'd3;
   localparam logic [3:0] S_DIV_INIT = 4'd4;
   localparam logic [3:0] S_DIV_TOP = 4'd5;
   localparam logic [3:0] S_DIV_LOOP = 4'd6;
   localparam logic [3:0] S_DIV_END = 4'd7;
   localparam logic [3:0] S_MEAN = 4'd8;
   localparam logic [3:0] S_MEAN_DIV = 4'd9;
   localparam logic [3:0] S_SQRT = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   localparam logic [4:0] SRC_ONE = 5'd0;
   localparam logic [4:0] SRC_N = 5'd1;
   localparam logic [4:0] SRC_SX = 5'd2;
   localparam logic [4:0] SRC_SY = 5'd3;
   localparam logic [4:0] SRC_SXX = 5'd4;
   localparam logic [4:0] SRC_SYY = 5'd5;
   localparam logic [4:0] SRC_SXY = 5'd6;
   localparam logic [4:0] SRC_S3X = 5'd7;
   localparam logic [4:0] SRC_S3Y = 5'd8;
   localparam logic [4:0] SRC_S2 = 5'd9;
   localparam logic [4:0] SRC_C = 5'd10;
   localparam logic [4:0] SRC_D = 5'd11;
   localparam logic [4:0] SRC_G = 5'd12;
   localparam logic [4:0] SRC_E = 5'd13;
   localparam logic [4:0] SRC_H = 5'd14;
   localparam logic [4:0] SRC_Q = 5'd15;
   localparam logic [4:0] SRC_TOT = 5'd16;
   localparam logic [4:0] SRC_CX = 5'd17;
   localparam logic [4:0] SRC_CY = 5'd18;

   localparam logic [1:0] OPC_LOAD = 2'd0;
   localparam logic [1:0] OPC_ADD = 2'd1;
   localparam logic [1:0] OPC_SUB = 2'd2;

   localparam logic [3:0] DST_NONE = 4'd0;
   localparam logic [3:0] DST_C = 4'd1;
   localparam logic [3:0] DST_D = 4'd2;
   localparam logic [3:0] DST_G = 4'd3;
   localparam logic [3:0] DST_E = 4'd4;
   localparam logic [3:0] DST_H = 4'd5;
   localparam logic [3:0] DST_DET = 4'd6;
   localparam logic [3:0] DST_NX = 4'd7;
   localparam logic [3:0] DST_NY = 4'd8;
   localparam logic [3:0] DST_Q = 4'd9;
   localparam logic [3:0] DST_TOT = 4'd10;

   localparam logic [4:0] STEP_SOLVE_END = 5'd15;
   localparam logic [4:0] STEP_RAD_BEGIN = 5'd16;
   localparam logic [4:0] STEP_LAST = 5'd26;

   function automatic uop_type ucode(input logic [4:0] step);
      uop_type u;
      case (step)
         5'd0: u = '{SRC_SXX, SRC_N, OPC_LOAD, DST_NONE};
         5'd1: u = '{SRC_SX, SRC_SX, OPC_SUB, DST_C};
         5'd2: u = '{SRC_SXY, SRC_N, OPC_LOAD, DST_NONE};
         5'd3: u = '{SRC_SX, SRC_SY, OPC_SUB, DST_D};
         5'd4: u = '{SRC_SYY, SRC_N, OPC_LOAD, DST_NONE};
         5'd5: u = '{SRC_SY, SRC_SY, OPC_SUB, DST_G};
         5'd6: u = '{SRC_S3X, SRC_N, OPC_LOAD, DST_NONE};
         5'd7: u = '{SRC_S2, SRC_SX, OPC_SUB, DST_E};
         5'd8: u = '{SRC_S3Y, SRC_N, OPC_LOAD, DST_NONE};
         5'd9: u = '{SRC_S2, SRC_SY, OPC_SUB, DST_H};
         5'd10: u = '{SRC_C, SRC_G, OPC_LOAD, DST_NONE};
         5'd11: u = '{SRC_D, SRC_D, OPC_SUB, DST_DET};
         5'd12: u = '{SRC_E, SRC_G, OPC_LOAD, DST_NONE};
         5'd13: u = '{SRC_H, SRC_D, OPC_SUB, DST_NX};
         5'd14: u = '{SRC_H, SRC_C, OPC_LOAD, DST_NONE};
         5'd15: u = '{SRC_E, SRC_D, OPC_SUB, DST_NY};
         5'd16: u = '{SRC_CX, SRC_CX, OPC_LOAD, DST_Q};
         5'd17: u = '{SRC_Q, SRC_N, OPC_LOAD, DST_NONE};
         5'd18: u = '{SRC_SXX, SRC_ONE, OPC_ADD, DST_NONE};
         5'd19: u = '{SRC_SX, SRC_CX, OPC_SUB, DST_NONE};
         5'd20: u = '{SRC_SX, SRC_CX, OPC_SUB, DST_TOT};
         5'd21: u = '{SRC_CY, SRC_CY, OPC_LOAD, DST_Q};
         5'd22: u = '{SRC_Q, SRC_N, OPC_LOAD, DST_NONE};
         5'd23: u = '{SRC_SYY, SRC_ONE, OPC_ADD, DST_NONE};
         5'd24: u = '{SRC_SY, SRC_CY, OPC_SUB, DST_NONE};
         5'd25: u = '{SRC_SY, SRC_CY, OPC_SUB, DST_NONE};
         5'd26: u = '{SRC_TOT, SRC_ONE, OPC_ADD, DST_TOT};
         default: u = '{SRC_ONE, SRC_ONE, OPC_LOAD, DST_NONE};
      endcase
      return u;
   endfunction

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [CW-1:0] n_ff, n_in;
   logic ovf_ff, ovf_in;
   logic [S1W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [S2W-1:0] sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;
   logic [S2W:0] s2_ff, s2_in;
   logic [S3W:0] s3x_ff, s3x_in, s3y_ff, s3y_in;
   logic signed [BW-1:0] c_ff, c_in, d_ff, d_in, g_ff, g_in, e_ff, e_in, h_ff, h_in;
   logic signed [BW-1:0] det_ff, det_in, nx_ff, nx_in, ny_ff, ny_in;
   logic signed [BW-1:0] q_ff, q_in, tot_ff, tot_in, acc_ff, acc_in;
   logic [BW-1:0] prod_ff, prod_in, ma_ff, ma_in, mb_ff, mb_in;
   logic neg_ff, neg_in, sel_y_ff, sel_y_in;
   logic [BW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [QW-1:0] qd_ff, qd_in;
   logic [KW-1:0] k_ff, k_in;
   logic signed [CEN_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [TW-1:0] dv_ff, dv_in, sv_ff, sv_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [CW-1:0] drem_ff, drem_in;
   logic [TCW-1:0] cnt_ff, cnt_in;

   snap_type snap;
   uop_type uop;
   logic signed [BW-1:0] a_val, b_val, acc_new, num_val;
   logic [BW-1:0] num_mag;
   logic [CW:0] d_trial;
   logic [TW-1:0] s_try, rad_full;
   logic signed [CEN_W-1:0] cen_val;

   function automatic logic signed [BW-1:0] operand(input logic [4:0] sel);
      logic signed [BW-1:0] v;
      case (sel)
         SRC_ONE: v = BW'(1);
         SRC_N: v = BW'(n_ff);
         SRC_SX: v = BW'(sx_ff);
         SRC_SY: v = BW'(sy_ff);
         SRC_SXX: v = BW'(sxx_ff);
         SRC_SYY: v = BW'(syy_ff);
         SRC_SXY: v = BW'(sxy_ff);
         SRC_S3X: v = BW'(s3x_ff);
         SRC_S3Y: v = BW'(s3y_ff);
         SRC_S2: v = BW'(s2_ff);
         SRC_C: v = c_ff;
         SRC_D: v = d_ff;
         SRC_G: v = g_ff;
         SRC_E: v = e_ff;
         SRC_H: v = h_ff;
         SRC_Q: v = q_ff;
         SRC_TOT: v = tot_ff;
         SRC_CX: v = BW'(cx_ff);
         SRC_CY: v = BW'(cy_ff);
         default: v = '0;
      endcase
      return v;
   endfunction

   assign snap = snap_type'(snap_data);
   assign res_data = '{cx_ff, cy_ff, rad_ff, status_ff};

   always_comb begin
      uop = ucode(step_ff);
      a_val = operand(uop.a_sel);
      b_val = operand(uop.b_sel);
      case (uop.opc)
         OPC_LOAD: acc_new = neg_ff ? -$signed(prod_ff) : $signed(prod_ff);
         OPC_ADD: acc_new = neg_ff ? acc_ff - $signed(prod_ff) : acc_ff + $signed(prod_ff);
         default: acc_new = neg_ff ? acc_ff + $signed(prod_ff) : acc_ff - $signed(prod_ff);
      endcase
      num_val = sel_y_ff ? ny_ff : nx_ff;
      num_mag = num_val[BW-1] ? BW'(-num_val) : BW'(num_val);
      d_trial = {drem_ff, dv_ff[TW-1]};
      s_try = sres_ff + sbit_ff;
      rad_full = (sres_ff + TW'(1)) >> 1;
      if (neg_ff) begin
         cen_val = (qd_ff > Q_NEG_LIM) ? CEN_MIN : CEN_W'(-qd_ff);
      end else begin
         cen_val = (qd_ff >= Q_NEG_LIM) ? CEN_MAX : CEN_W'(qd_ff);
      end

      state_in = state_ff;
      step_in = step_ff;
      n_in = n_ff;
      ovf_in = ovf_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sxx_in = sxx_ff;
      syy_in = syy_ff;
      sxy_in = sxy_ff;
      s2_in = s2_ff;
      s3x_in = s3x_ff;
      s3y_in = s3y_ff;
      c_in = c_ff;
      d_in = d_ff;
      g_in = g_ff;
      e_in = e_ff;
      h_in = h_ff;
      det_in = det_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      q_in = q_ff;
      tot_in = tot_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      neg_in = neg_ff;
      sel_y_in = sel_y_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      qd_in = qd_ff;
      k_in = k_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      rad_in = rad_ff;
      status_in = status_ff;
      dv_in = dv_ff;
      sv_in = sv_ff;
      sres_in = sres_ff;
      sbit_in = sbit_ff;
      drem_in = drem_ff;
      cnt_in = cnt_ff;
      snap_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            snap_ready = 1'b1;
            if (snap_valid) begin
               n_in = snap.n;
               ovf_in = snap.ovf;
               sx_in = snap.sx;
               sy_in = snap.sy;
               sxx_in = snap.sxx;
               syy_in = snap.syy;
               sxy_in = snap.sxy;
               s2_in = (S2W + 1)'(snap.sxx) + (S2W + 1)'(snap.syy);
               s3x_in = (S3W + 1)'(snap.sxxx) + (S3W + 1)'(snap.sxyy);
               s3y_in = (S3W + 1)'(snap.sxxy) + (S3W + 1)'(snap.syyy);
               step_in = '0;
               if (snap.n < CW'(MIN_POINTS)) begin
                  cx_in = '0;
                  cy_in = '0;
                  rad_in = '0;
                  status_in = STAT_FEW;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL_SETUP;
               end
            end
         end
         S_MUL_SETUP: begin
            ma_in = a_val[BW-1] ? BW'(-a_val) : BW'(a_val);
            mb_in = b_val[BW-1] ? BW'(-b_val) : BW'(b_val);
            neg_in = a_val[BW-1] ^ b_val[BW-1];
            prod_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mb_ff == '0) begin
               state_in = S_MUL_ACC;
            end else begin
               if (mb_ff[0]) begin
                  prod_in = prod_ff + ma_ff;
               end
               ma_in = ma_ff << 1;
               mb_in = mb_ff >> 1;
            end
         end
         S_MUL_ACC: begin
            acc_in = acc_new;
            case (uop.dest)
               DST_C: c_in = acc_new;
               DST_D: d_in = acc_new;
               DST_G: g_in = acc_new;
               DST_E: e_in = acc_new;
               DST_H: h_in = acc_new;
               DST_DET: det_in = acc_new;
               DST_NX: nx_in = acc_new;
               DST_NY: ny_in = acc_new;
               DST_Q: q_in = acc_new;
               DST_TOT: tot_in = acc_new;
               default: ;
            endcase
            if (step_ff == STEP_SOLVE_END) begin
               if (!det_ff[BW-1] && det_ff != '0) begin
                  sel_y_in = 1'b0;
                  state_in = S_DIV_INIT;
               end else begin
                  cx_in = '0;
                  cy_in = '0;
                  rad_in = '0;
                  status_in = STAT_SINGULAR;
                  state_in = S_DONE;
               end
            end else if (step_ff == STEP_LAST) begin
               state_in = S_MEAN;
            end else begin
               step_in = step_ff + 5'd1;
               state_in = S_MUL_SETUP;
            end
         end
         S_DIV_INIT: begin
            rem_in = num_mag + BW'(det_ff);
            den_in = BW'(det_ff) << (CEN_W + 1);
            neg_in = num_val[BW-1];
            state_in = S_DIV_TOP;
         end
         S_DIV_TOP: begin
            if (rem_ff >= den_ff) begin
               qd_in = Q_SAT;
               state_in = S_DIV_END;
            end else begin
               qd_in = '0;
               den_in = den_ff >> 1;
               k_in = KW'(CEN_W - 1);
               state_in = S_DIV_LOOP;
            end
         end
         S_DIV_LOOP: begin
            if (rem_ff >= den_ff) begin
               rem_in = rem_ff - den_ff;
               qd_in = qd_ff | (QW'(1) << k_ff);
            end
            den_in = den_ff >> 1;
            if (k_ff == '0) begin
               state_in = S_DIV_END;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end
         S_DIV_END: begin
            if (!sel_y_ff) begin
               cx_in = cen_val;
               sel_y_in = 1'b1;
               state_in = S_DIV_INIT;
            end else begin
               cy_in = cen_val;
               step_in = STEP_RAD_BEGIN;
               state_in = S_MUL_SETUP;
            end
         end
         S_MEAN: begin
            dv_in = {tot_ff[TW-3:0], 2'b00};
            drem_in = '0;
            cnt_in = DIV_STEPS;
            state_in = S_MEAN_DIV;
         end
         S_MEAN_DIV: begin
            if (cnt_ff == '0) begin
               sv_in = dv_ff;
               sres_in = '0;
               sbit_in = SQ_TOP;
               state_in = S_SQRT;
            end else begin
               if (d_trial >= {1'b0, n_ff}) begin
                  drem_in = CW'(d_trial - {1'b0, n_ff});
                  dv_in = {dv_ff[TW-2:0], 1'b1};
               end else begin
                  drem_in = d_trial[CW-1:0];
                  dv_in = {dv_ff[TW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - TCW'(1);
            end
         end
         S_SQRT: begin
            if (sbit_ff == '0) begin
               rad_in = (rad_full[TW-1:RAD_W] != '0) ? RAD_MAX : rad_full[RAD_W-1:0];
               status_in = ovf_ff ? STAT_DROPPED : STAT_OK;
               state_in = S_DONE;
            end else begin
               if (sv_ff >= s_try) begin
                  sv_in = sv_ff - s_try;
                  sres_in = (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_in = sres_ff >> 1;
               end
               sbit_in = sbit_ff >> 2;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      n_ff <= n_in;
      ovf_ff <= ovf_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sxx_ff <= sxx_in;
      syy_ff <= syy_in;
      sxy_ff <= sxy_in;
      s2_ff <= s2_in;
      s3x_ff <= s3x_in;
      s3y_ff <= s3y_in;
      c_ff <= c_in;
      d_ff <= d_in;
      g_ff <= g_in;
      e_ff <= e_in;
      h_ff <= h_in;
      det_ff <= det_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      q_ff <= q_in;
      tot_ff <= tot_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      sel_y_ff <= sel_y_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      qd_ff <= qd_in;
      k_ff <= k_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      rad_ff <= rad_in;
      status_ff <= status_in;
      dv_ff <= dv_in;
      sv_ff <= sv_in;
      sres_ff <= sres_in;
      sbit_ff <= sbit_in;
      drem_ff <= drem_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* rtl/core/least_squares_circle_fit_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_circle_fit_unit
// Algebraic least-squares circle fit over a stream of points.
// ----------------------------------------------------------------------------
// Points are taken at one beat per cycle into a three-stage product pipeline
// and the moment sums; the beat marked last closes the set, which waits in a
// two-entry queue for the solver, so point intake stalls only when a third set
// closes while two are still queued. The solver runs one set at a time through
// a single shift-add multiplier for its 27 products, with two centre divisions
// after the products of the normal equations and a mean division and a square
// root after those of the radius sum; a set of fewer than three points goes
// straight to the result.
// Results leave through a one-entry output register.
module least_squares_circle_fit_unit
   import lscf_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_point,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SNAP_W = 1 + CW + 2 * (COORD_W + CW) + 3 * (2 * COORD_W + CW)
                         + 4 * (3 * COORD_W + CW);

   logic snap_valid, snap_ready, q_valid, q_ready, res_valid, res_ready;
   logic [SNAP_W-1:0] snap_data, q_data;
   rsp_type res_data, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   lscf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_point  (req_point),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data)
   );

   lscf_snap_queue #(.W(SNAP_W)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (snap_valid),
      .wr_ready (snap_ready),
      .wr_data  (snap_data),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   lscf_solver #(.MAX_POINTS(MAX_POINTS)) u_solver (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (q_valid),
      .snap_ready (q_ready),
      .snap_data  (q_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_data   (res_data)
   );

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign res_ready = !rsp_valid_ff || rsp_pop;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_in = res_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // a closed set that cannot be queued holds the point intake
   a_stall_on_full_queue: assert property (@(posedge clock) disable iff (reset)
      snap_valid && !snap_ready |-> req_full)
      else $error("point intake open while a closed set is blocked");

   // too few points and singular sets carry no geometry
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_data.fit_status == STAT_FEW
                     || rsp_data.fit_status == STAT_SINGULAR)
      |-> rsp_data.center_x == '0 && rsp_data.center_y == '0
          && rsp_data.radius == '0)
      else $error("failed fit with non-zero fields");

   // a popped result with no new one behind it empties the output
   a_pop_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !res_valid |=> rsp_empty)
      else $error("result repeated after pop");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the least-squares circle fit unit. Point sets are
// streamed in through the queue-style input and each fit result is checked
// against an exact wide-integer prediction of the centre, radius and status.
// Covered: short sets, collinear and coincident sets, corner coordinates,
// far centres, the point limit, and random noisy circles, lines and scattered
// points under three different back-pressure mixes.
// ----------------------------------------------------------------------------
module tb;
   import lscf_pkg::*;

   localparam int HALF = 5;
   localparam int POINT_LIMIT = 1024;
   localparam int STALL_LIMIT = 40000;

   typedef logic signed [255:0] wide_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_point = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   least_squares_circle_fit_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_point (req_point),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #HALF clock = ~clock;

   // predictor state
   int unsigned held_count;
   logic        drop_seen;
   logic [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xxx, acc_yyy, acc_xy, acc_xyy, acc_xxy;
   rsp_type     expected_fits[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int points_sent = 0;
   int fits_checked = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int quiet_cycles = 0;

   function automatic wide_t widen(logic [63:0] v);
      widen = {192'b0, v};
   endfunction

   function automatic logic signed [CEN_W-1:0] centre_round(wide_t num, wide_t det);
      wide_t mag;
      wide_t q;
      mag = (num < 0) ? -num : num;
      q = (mag + det) / (det + det);
      if (num < 0)
         centre_round = (q > 524288) ? CEN_MIN : CEN_W'(-q);
      else
         centre_round = (q > 524287) ? CEN_MAX : CEN_W'(q);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      root64 = res;
   endfunction

   task automatic clear_moments();
      held_count = 0;
      drop_seen = 1'b0;
      acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xxx = 0; acc_yyy = 0;
      acc_xy = 0; acc_xyy = 0; acc_xxy = 0;
   endtask

   task automatic predict_circle(req_type p);
      logic [63:0]     x, y;
      wide_t           n, c_t, d_t, g_t, e_t, h_t, det, sx, sy, s2;
      rsp_type         r;
      longint          cxl, cyl, nl, tx, ty;
      longint unsigned total, s, rad;
      x = {48'b0, p.point_x};
      y = {48'b0, p.point_y};
      if (held_count < POINT_LIMIT) begin
         acc_x += x; acc_y += y;
         acc_xx += x * x; acc_yy += y * y;
         acc_xxx += x * x * x; acc_yyy += y * y * y;
         acc_xy += x * y; acc_xyy += x * y * y; acc_xxy += x * x * y;
         held_count++;
      end else begin
         drop_seen = 1'b1;
      end
      if (!p.end_of_set) return;
      r = '0;
      if (held_count < MIN_POINTS) begin
         r.fit_status = STAT_FEW;
      end else begin
         n = widen(held_count);
         sx = widen(acc_x);
         sy = widen(acc_y);
         s2 = widen(acc_xx + acc_yy);
         c_t = n * widen(acc_xx) - sx * sx;
         d_t = n * widen(acc_xy) - sx * sy;
         g_t = n * widen(acc_yy) - sy * sy;
         e_t = n * widen(acc_xxx + acc_xyy) - s2 * sx;
         h_t = n * widen(acc_xxy + acc_yyy) - s2 * sy;
         det = c_t * g_t - d_t * d_t;
         if (det <= 0) begin
            r.fit_status = STAT_SINGULAR;
         end else begin
            r.center_x = centre_round(e_t * g_t - h_t * d_t, det);
            r.center_y = centre_round(h_t * c_t - e_t * d_t, det);
            cxl = r.center_x;
            cyl = r.center_y;
            nl = held_count;
            tx = longint'(acc_xx) - 2 * cxl * longint'(acc_x) + nl * cxl * cxl;
            ty = longint'(acc_yy) - 2 * cyl * longint'(acc_y) + nl * cyl * cyl;
            total = longint'(tx) + longint'(ty);
            s = root64((4 * total) / held_count);
            rad = (s + 1) >> 1;
            r.radius = (rad > RAD_MAX) ? RAD_MAX : RAD_W'(rad);
            r.fit_status = drop_seen ? STAT_DROPPED : STAT_OK;
         end
      end
      expected_fits = {expected_fits, r};
      clear_moments();
   endtask

   task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
      req_type p;
      p.point_x = x;
      p.point_y = y;
      p.end_of_set = last;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         req_point <= req_type'($urandom);
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_point <= p;
      do @(posedge clock); while (req_full);
      predict_circle(p);
      points_sent++;
   endtask

   task automatic release_push();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   // result checker
   always begin
      rsp_type want;
      @(negedge clock);
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clock);
      if (rsp_pop && !rsp_empty) begin
         fits_checked++;
         status_seen[rsp_data.fit_status]++;
         if (expected_fits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: cx=%0d cy=%0d r=%0d st=%0d",
                        rsp_data.center_x, rsp_data.center_y, rsp_data.radius,
                        rsp_data.fit_status);
         end else begin
            want = expected_fits.pop_front();
            if (rsp_data.center_x !== want.center_x || rsp_data.center_y !== want.center_y ||
                rsp_data.radius !== want.radius || rsp_data.fit_status !== want.fit_status)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("fit %0d mismatch: exp cx=%0d cy=%0d r=%0d st=%0d, got cx=%0d cy=%0d r=%0d st=%0d",
                           fits_checked, want.center_x, want.center_y, want.radius,
                           want.fit_status, rsp_data.center_x, rsp_data.center_y,
                           rsp_data.radius, rsp_data.fit_status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_few_points();
      send_point(16'h0000, 16'hFFFF, 1'b1);
      send_point(16'hFFFF, 16'h0000, 1'b0);
      send_point(16'h0000, 16'h0000, 1'b1);
   endtask

   task automatic test_singular();
      send_point(16'd100, 16'd200, 1'b0);
      send_point(16'd300, 16'd400, 1'b0);
      send_point(16'd500, 16'd600, 1'b1);
      repeat (3) send_point(16'hFFFF, 16'hFFFF, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b1);
   endtask

   task automatic test_corner_circle();
      send_point(16'h0000, 16'h0000, 1'b0);
      send_point(16'hFFFF, 16'h0000, 1'b0);
      send_point(16'h0000, 16'hFFFF, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b1);
      send_point(16'h5555, 16'hAAAA, 1'b0);
      send_point(16'hAAAA, 16'h5555, 1'b0);
      send_point(16'h8000, 16'h8000, 1'b1);
   endtask

   task automatic test_far_centre();
      send_point(16'd0, 16'd0, 1'b0);
      send_point(16'd32768, 16'd1, 1'b0);
      send_point(16'd65535, 16'd0, 1'b1);
      send_point(16'd1000, 16'd0, 1'b0);
      send_point(16'd0, 16'd1000, 1'b0);
      send_point(16'd501, 16'd500, 1'b1);
   endtask

   task automatic random_circle_set(int count, bit line_set);
      real cxr, cyr, rr, ang, xr, yr;
      int  k;
      cxr = $urandom_range(65535);
      cyr = $urandom_range(65535);
      rr = $urandom_range(1, 40000);
      for (k = 0; k < count; k++) begin
         ang = $urandom_range(1000000) * 6.283185307 / 1000000.0;
         if (line_set) begin
            xr = cxr + k * 37.0;
            yr = cyr + k * 11.0;
         end else begin
            xr = cxr + rr * $cos(ang) + $urandom_range(64) - 32.0;
            yr = cyr + rr * $sin(ang) + $urandom_range(64) - 32.0;
         end
         if (xr < 0.0) xr = 0.0;
         if (xr > 65535.0) xr = 65535.0;
         if (yr < 0.0) yr = 0.0;
         if (yr > 65535.0) yr = 65535.0;
         send_point(16'($rtoi(xr)), 16'($rtoi(yr)), k == count - 1);
      end
   endtask

   task automatic test_point_limit();
      random_circle_set(POINT_LIMIT + 1, 1'b0);
   endtask

   task automatic test_random_sets(int point_goal);
      int goal;
      int pick;
      int count;
      int k;
      goal = points_sent + point_goal;
      while (points_sent < goal) begin
         pick = $urandom_range(99);
         count = (pick < 8) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         if (pick < 60) begin
            random_circle_set(count, 1'b0);
         end else if (pick < 70) begin
            random_circle_set(count, 1'b1);
         end else begin
            for (k = 0; k < count; k++)
               send_point(16'($urandom), 16'($urandom), k == count - 1);
         end
      end
   endtask

   initial begin
      clear_moments();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_few_points();
      test_singular();
      test_corner_circle();
      test_far_centre();
      test_point_limit();
      send_idle_pct = 38; recv_idle_pct = 48;
      test_random_sets(40);
      send_idle_pct = 48; recv_idle_pct = 38;
      test_random_sets(40);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_sets(40);
      release_push();
      while (expected_fits.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d points and %0d fits (ok %0d, few %0d, singular %0d, dropped %0d)",
               points_sent, fits_checked, status_seen[STAT_OK], status_seen[STAT_FEW],
               status_seen[STAT_SINGULAR], status_seen[STAT_DROPPED]);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/lscf_pkg.sv
rtl/core/lscf_front.sv
rtl/core/lscf_snap_queue.sv
rtl/core/lscf_solver.sv
rtl/core/least_squares_circle_fit_unit.sv
test/tb.sv
